@@ hw/rtl/min_dot_product_pairing_top_macros.svh @@
// Assertion macros shared by the checker of the minimum dot product block.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef MIN_DOT_PRODUCT_PAIRING_TOP_MACROS_SVH
`define MIN_DOT_PRODUCT_PAIRING_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mdp_pkg.sv @@
// Package for the minimum dot product block: default sizes, result field widths
// and the accumulator limits. No dependencies.
package mdp_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 18;

  localparam int SUM_W  = 45;
  localparam int PAIR_W = 11;
  localparam int OUT_W  = SUM_W + PAIR_W;
  localparam int ACC_W  = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sh0000_0FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SUM_MIN = 64'shFFFF_F000_0000_0000;

endpackage

@@ hw/rtl/min_dot_product_pairing_top.sv @@
// Loads one pair transfer per cycle while the input is ready. For a set of n >= 2 pairs a bubble
// sort runs first; then the shared-multiplier sum takes the pairs one at a time, and the result is
// offered when the sum is done. A result still held at the output delays this; the input is
// not ready until it is offered.
// Reset clears the fill count, the drop flag, the output and the sequencer; not the stores.
// Depends on mdp_pkg and mdp_ram.
module min_dot_product_pairing_top #(
  parameter int DEPTH      = mdp_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = mdp_pkg::VALUE_BITS_DEF,
  localparam int IN_W      = ((2 * VALUE_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // a_value, b_value
  input  logic [IN_W-1:0]            s_axis_tdata,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // dot_sum, pair_count
  output logic [mdp_pkg::OUT_W-1:0]  m_axis_tdata,
  // overflow
  output logic                       m_axis_tuser
);

  import mdp_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VB     = VALUE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD0, ST_LD0, ST_CMP, ST_TAIL, ST_SRD, ST_SMUL, ST_SACC, ST_DONE
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         fill_q;
  logic                     drop_q;
  logic [ADDR_W-1:0]        lim_q;
  logic [ADDR_W-1:0]        j_q;
  logic [ADDR_W-1:0]        last_idx_q;
  logic signed [VB-1:0]     cur_a_q;
  logic signed [VB-1:0]     cur_b_q;
  logic signed [2*VB-1:0]   prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_sum_q;
  logic [PAIR_W-1:0]        out_cnt_q;
  logic                     out_ovf_q;

  logic                     in_xfer;
  logic                     room;
  logic [CNT_W-1:0]         fill_d;
  logic [ADDR_W-1:0]        n_last;
  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        raddr;
  logic [VB-1:0]            wdata_a;
  logic [VB-1:0]            wdata_b;
  logic [VB-1:0]            rdata_a;
  logic [VB-1:0]            rdata_b;
  logic signed [VB-1:0]     rd_a;
  logic signed [VB-1:0]     rd_b;
  logic                     a_gt;
  logic                     b_lt;
  logic signed [VB-1:0]     keep_a;
  logic signed [VB-1:0]     keep_b;
  logic signed [2*VB-1:0]   prod_d;
  logic signed [ACC_W:0]    sum_w;
  logic signed [ACC_W-1:0]  acc_d;
  logic [SUM_W-1:0]         clamp;
  logic [PAIR_W+CNT_W-1:0]  cnt_ext;
  logic                     out_free;
  logic                     out_load;
  logic                     out_valid_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign room     = fill_q < DEPTH_C;
  assign fill_d   = room ? fill_q + CNT_W'(1) : fill_q;
  assign n_last   = ADDR_W'(fill_d - CNT_W'(1));
  assign rd_a     = rdata_a;
  assign rd_b     = rdata_b;
  assign a_gt     = rd_a > cur_a_q;
  assign b_lt     = rd_b < cur_b_q;
  assign keep_a   = a_gt ? cur_a_q : rd_a;
  assign keep_b   = b_lt ? cur_b_q : rd_b;
  assign prod_d   = rd_a * rd_b;
  assign sum_w    = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_q);
  assign acc_d    = (sum_w[ACC_W] != sum_w[ACC_W-1]) ? (sum_w[ACC_W] ? ACC_MIN : ACC_MAX)
                                                     : sum_w[ACC_W-1:0];
  assign clamp    = (acc_q > SUM_MAX) ? SUM_MAX[SUM_W-1:0] :
                    (acc_q < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : acc_q[SUM_W-1:0];
  assign cnt_ext  = {{PAIR_W{1'b0}}, fill_q};
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_sum_q};
  assign m_axis_tuser  = out_ovf_q;

  always_comb begin
    we      = 1'b0;
    waddr   = fill_q[ADDR_W-1:0];
    wdata_a = s_axis_tdata[VB-1:0];
    wdata_b = s_axis_tdata[2*VB-1:VB];
    raddr   = '0;
    case (state_q)
      ST_LOAD: begin
        we = in_xfer && room;
      end
      ST_LD0: begin
        raddr = ADDR_W'(1);
      end
      ST_CMP: begin
        we      = 1'b1;
        waddr   = j_q - ADDR_W'(1);
        wdata_a = a_gt ? rd_a : cur_a_q;
        wdata_b = b_lt ? rd_b : cur_b_q;
        raddr   = j_q + ADDR_W'(1);
      end
      ST_TAIL: begin
        we      = 1'b1;
        waddr   = lim_q;
        wdata_a = cur_a_q;
        wdata_b = cur_b_q;
      end
      ST_SRD: begin
        raddr = j_q;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  mdp_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_a),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  mdp_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_b),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      lim_q       <= '0;
      j_q         <= '0;
      last_idx_q  <= '0;
      cur_a_q     <= '0;
      cur_b_q     <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_cnt_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            fill_q <= fill_d;
            if (!room) begin
              drop_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              acc_q      <= '0;
              lim_q      <= n_last;
              last_idx_q <= n_last;
              j_q        <= '0;
              state_q    <= (fill_d == CNT_W'(1)) ? ST_SRD : ST_RD0;
            end
          end
        end
        ST_RD0: begin
          state_q <= ST_LD0;
        end
        ST_LD0: begin
          cur_a_q <= rd_a;
          cur_b_q <= rd_b;
          j_q     <= ADDR_W'(1);
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          cur_a_q <= keep_a;
          cur_b_q <= keep_b;
          if (j_q == lim_q) begin
            state_q <= ST_TAIL;
          end else begin
            j_q <= j_q + ADDR_W'(1);
          end
        end
        ST_TAIL: begin
          if (lim_q == ADDR_W'(1)) begin
            j_q     <= '0;
            state_q <= ST_SRD;
          end else begin
            lim_q   <= lim_q - ADDR_W'(1);
            state_q <= ST_LD0;
          end
        end
        ST_SRD: begin
          state_q <= ST_SMUL;
        end
        ST_SMUL: begin
          prod_q  <= prod_d;
          state_q <= ST_SACC;
        end
        ST_SACC: begin
          acc_q <= acc_d;
          if (j_q == last_idx_q) begin
            state_q <= ST_DONE;
          end else begin
            j_q     <= j_q + ADDR_W'(1);
            state_q <= ST_SRD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_sum_q   <= clamp;
            out_cnt_q   <= cnt_ext[PAIR_W-1:0];
            out_ovf_q   <= drop_q;
            fill_q      <= '0;
            drop_q      <= 1'b0;
            state_q     <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/mdp_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module mdp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/mdp_checker.sv @@
// Port-level checker for the minimum dot product block, bound to the top level.
// Depends on mdp_pkg and min_dot_product_pairing_top_macros.svh.
`include "min_dot_product_pairing_top_macros.svh"

module mdp_checker #(
  parameter int DEPTH      = mdp_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = mdp_pkg::VALUE_BITS_DEF,
  localparam int IN_W      = ((2 * VALUE_BITS + 7) / 8) * 8
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [IN_W-1:0]           s_axis_tdata,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [mdp_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser
);

  import mdp_pkg::*;

  localparam logic [PAIR_W+31:0] DEPTH_EXT = {{PAIR_W{1'b0}}, 32'(DEPTH)};
  localparam logic [PAIR_W-1:0]  FULL_CNT  = DEPTH_EXT[PAIR_W-1:0];

  logic [PAIR_W-1:0] pair_count;
  logic              last_xfer;
  logic              in_stall;
  logic              out_stall;
  logic [IN_W:0]     in_word;
  logic [OUT_W:0]    out_word;

  assign pair_count = m_axis_tdata[OUT_W-1:SUM_W];
  assign last_xfer  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign in_stall   = s_axis_tvalid && !s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign in_word    = {s_axis_tlast, s_axis_tdata};
  assign out_word   = {m_axis_tuser, m_axis_tdata};

  // A stalled result keeps its contents.
  `MDP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "result not held")

  // A stalled input transfer keeps its contents.
  `MDP_ASSERT_NEXT(a_in_hold, in_stall, s_axis_tvalid && $stable(in_word), "input not held")

  // The sort and sum start right after the closing transfer, so input stalls.
  `MDP_ASSERT_NEXT(a_busy_after_last, last_xfer, !s_axis_tready, "input ready during computation")

  // A new result only appears at the end of a computation.
  `MDP_ASSERT_NOW(a_result_after_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without computation")

  // Dropped pairs mean the store was full.
  `MDP_ASSERT_NOW(a_ovf_full, m_axis_tvalid && m_axis_tuser, pair_count == FULL_CNT, "overflow with store not full")

endmodule

bind min_dot_product_pairing_top mdp_checker #(
  .DEPTH      (DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_mdp_checker (.*);
